### rtl/mtm_pkg.sv
// ----------------------------------------------------------------------------
// mtm_pkg
// Shared constants and codes of the multichannel tone mixer.
// ----------------------------------------------------------------------------
package mtm_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    localparam logic [7:0] WAVE_SQUARE = 8'd0;
    localparam logic [7:0] WAVE_SAW    = 8'd1;
    localparam logic [7:0] WAVE_TRI    = 8'd2;
    localparam logic [7:0] WAVE_NOISE  = 8'd3;

    localparam logic [16:0] SR_RESET   = 17'd44100;
    localparam logic [31:0] SEED_RESET = 32'd12345;
    localparam logic [31:0] LCG_MUL    = 32'd1664525;
    localparam logic [31:0] LCG_ADD    = 32'd1013904223;

    localparam logic signed [19:0] MIX_MAX = 20'sd32767;
    localparam logic signed [19:0] MIX_MIN = -20'sd32768;

endpackage

### rtl/multichannel_tone_mixer.sv
// ----------------------------------------------------------------------------
// multichannel_tone_mixer
// Programmable tone generator: channel writes, stop-all and sample ticks.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one action per transaction: tuser holds the action code,
//   tdata the channel write payload. m_axis returns one signed 16-bit sample
//   for each sample tick; writes and stop-all return nothing.
//   i_cfg_wen/i_cfg_wdata load the sample rate; write only while idle.
// Operation:
//   A sample tick walks the channels one at a time through a single shared
//   multiplier and a 32-step restoring divider: a silent channel needs no
//   divide, an active one up to 4 divides.
//   s_axis_tready is high only while the sequencer is idle.
// Reset:
//   Synchronous, active low. All channels silent, phase and counts zero,
//   sample rate 44100, noise seed 12345.
// Stall:
//   A finished sample waits in the output register; a tick that completes
//   while the previous sample is still unread holds until it is taken.
// ----------------------------------------------------------------------------
module multichannel_tone_mixer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [16:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: channel[2:0], tone_freq[18:3], wave_kind[26:19], loudness[34:27]
    input  logic [39:0] s_axis_tdata,
    // tuser: action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: sample[15:0]
    output logic [15:0] m_axis_tdata
);
    import mtm_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_PCHK = 4'd2;
    localparam logic [3:0] S_ENVA = 4'd3;
    localparam logic [3:0] S_POS  = 4'd4;
    localparam logic [3:0] S_WAVE = 4'd5;
    localparam logic [3:0] S_WDIV = 4'd6;
    localparam logic [3:0] S_NSED = 4'd7;
    localparam logic [3:0] S_VAL  = 4'd8;
    localparam logic [3:0] S_ACC  = 4'd9;
    localparam logic [3:0] S_NEXT = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;
    localparam logic [3:0] S_DIVW = 4'd12;
    localparam logic [3:0] S_ENVD = 4'd13;

    logic [15:0] r_freq   [NUM_CHANNELS];
    logic [7:0]  r_wave   [NUM_CHANNELS];
    logic [7:0]  r_vol    [NUM_CHANNELS];
    logic [31:0] r_phase  [NUM_CHANNELS];
    logic [31:0] r_played [NUM_CHANNELS];

    logic [16:0] r_sr;
    logic [31:0] r_seed, n_seed;
    logic [3:0]  r_state, n_state, r_ret, n_ret;
    logic [CH_W-1:0] r_ch, n_ch;
    logic [16:0] r_per, n_per;
    logic [15:0] r_half, n_half;
    logic [12:0] r_amp, n_amp;
    logic        r_hi, n_hi;
    logic signed [16:0] r_val, n_val;
    logic signed [19:0] r_mix, n_mix;
    logic [31:0] r_prod;
    logic        r_ovalid;
    logic [15:0] r_odata;

    logic        dv_go;
    logic [31:0] dv_num;
    logic [16:0] dv_den;
    logic        r_dv_busy;
    logic [5:0]  r_dv_cnt;
    logic [31:0] r_dv_quo;
    logic [16:0] r_dv_rem;
    logic [16:0] r_dv_den;
    logic [17:0] dv_shift;

    logic [31:0] mul_a, mul_b;

    logic        in_acc;
    logic [2:0]  in_ch;
    logic [15:0] in_freq;
    logic [7:0]  in_wave;
    logic [7:0]  in_vol;
    logic        wr_en;
    logic        adv_en;

    logic [15:0] c_freq;
    logic [7:0]  c_wave, c_vol;
    logic [31:0] c_played;
    logic [15:0] dlen;
    logic [12:0] env_base, env_span;
    logic [13:0] a2;
    logic [16:0] pos;
    logic [15:0] half_c;
    logic signed [16:0] amp_s;
    logic signed [16:0] q_s;
    logic signed [19:0] mix_out;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign in_ch   = s_axis_tdata[2:0];
    assign in_freq = s_axis_tdata[18:3];
    assign in_wave = s_axis_tdata[26:19];
    assign in_vol  = s_axis_tdata[34:27];
    assign wr_en   = in_acc && (s_axis_tuser == ACT_WRITE) && (int'(in_ch) < NUM_CHANNELS);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign c_freq   = r_freq[r_ch];
    assign c_wave   = r_wave[r_ch];
    assign c_vol    = r_vol[r_ch];
    assign c_played = r_played[r_ch];
    assign dlen     = r_sr[16:1];
    assign env_base = (c_wave == WAVE_NOISE) ? 13'd0 : 13'(c_vol) * 13'd12;
    assign env_span = (c_wave == WAVE_NOISE) ? 13'(c_vol) * 13'd30 : 13'(c_vol) * 13'd18;
    assign a2       = {1'b0, r_amp} << 1;
    assign pos      = r_dv_rem;
    assign half_c   = (r_per[16:1] == 16'd0) ? 16'd1 : r_per[16:1];
    assign amp_s    = signed'({4'd0, r_amp});
    assign q_s      = signed'({1'b0, r_dv_quo[15:0]});
    assign mix_out  = (r_mix > MIX_MAX) ? MIX_MAX : ((r_mix < MIX_MIN) ? MIX_MIN : r_mix);

    // shared divider step
    assign dv_shift = {r_dv_rem, r_dv_quo[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_cnt  <= 6'd0;
        end else if (dv_go) begin
            r_dv_busy <= 1'b1;
            r_dv_cnt  <= 6'd32;
            r_dv_quo  <= dv_num;
            r_dv_rem  <= 17'd0;
            r_dv_den  <= dv_den;
        end else if (r_dv_busy) begin
            if (dv_shift >= {1'b0, r_dv_den}) begin
                r_dv_rem <= 17'(dv_shift - {1'b0, r_dv_den});
                r_dv_quo <= {r_dv_quo[30:0], 1'b1};
            end else begin
                r_dv_rem <= dv_shift[16:0];
                r_dv_quo <= {r_dv_quo[30:0], 1'b0};
            end
            r_dv_cnt <= r_dv_cnt - 6'd1;
            if (r_dv_cnt == 6'd1) begin
                r_dv_busy <= 1'b0;
            end
        end
    end

    // shared multiplier, registered
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_ch    = r_ch;
        n_per   = r_per;
        n_half  = r_half;
        n_amp   = r_amp;
        n_hi    = r_hi;
        n_val   = r_val;
        n_mix   = r_mix;
        n_seed  = r_seed;
        dv_go   = 1'b0;
        dv_num  = 32'd0;
        dv_den  = 17'd1;
        mul_a   = 32'd0;
        mul_b   = 32'd0;
        adv_en  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (s_axis_tuser == ACT_TICK)) begin
                    n_ch    = '0;
                    n_mix   = '0;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if ((c_freq == 16'd0) || (c_vol == 8'd0)) begin
                    n_state = S_NEXT;
                end else begin
                    dv_go   = 1'b1;
                    dv_num  = {15'd0, r_sr};
                    dv_den  = {1'b0, c_freq};
                    n_ret   = S_PCHK;
                    n_state = S_DIVW;
                end
            end
            S_PCHK: begin
                n_per = r_dv_quo[16:0];
                if (r_dv_quo[16:0] == 17'd0) begin
                    n_state = S_NEXT;
                end else if (c_played < {16'd0, dlen}) begin
                    mul_a   = 32'(env_span);
                    mul_b   = 32'(dlen - c_played[15:0]);
                    n_state = S_ENVD;
                end else begin
                    n_amp   = env_base;
                    n_state = S_POS;
                end
            end
            S_ENVD: begin
                dv_go   = 1'b1;
                dv_num  = r_prod;
                dv_den  = {1'b0, dlen};
                n_ret   = S_ENVA;
                n_state = S_DIVW;
            end
            S_ENVA: begin
                n_amp   = 13'(env_base + r_dv_quo[12:0]);
                n_state = S_POS;
            end
            S_POS: begin
                n_half  = half_c;
                dv_go   = 1'b1;
                dv_num  = r_phase[r_ch];
                dv_den  = r_per;
                n_ret   = S_WAVE;
                n_state = S_DIVW;
            end
            S_WAVE: begin
                n_val   = '0;
                n_state = S_ACC;
                case (c_wave)
                    WAVE_SQUARE: begin
                        n_val = (pos < {1'b0, r_per[16:1]}) ? amp_s : -amp_s;
                    end
                    WAVE_SAW: begin
                        mul_a   = 32'(a2);
                        mul_b   = 32'(pos);
                        n_state = S_WDIV;
                    end
                    WAVE_TRI: begin
                        mul_a = 32'(a2);
                        if (pos < {1'b0, r_half}) begin
                            n_hi  = 1'b0;
                            mul_b = 32'(pos);
                        end else begin
                            n_hi  = 1'b1;
                            mul_b = 32'(pos - {1'b0, r_half});
                        end
                        n_state = S_WDIV;
                    end
                    WAVE_NOISE: begin
                        if (r_amp != 13'd0) begin
                            mul_a   = r_seed;
                            mul_b   = LCG_MUL;
                            n_state = S_NSED;
                        end
                    end
                    default: begin
                        n_val = '0;
                    end
                endcase
            end
            S_WDIV: begin
                dv_go   = 1'b1;
                dv_num  = r_prod;
                dv_den  = (c_wave == WAVE_SAW) ? r_per : {1'b0, r_half};
                n_ret   = S_VAL;
                n_state = S_DIVW;
            end
            S_NSED: begin
                n_seed  = r_prod + LCG_ADD;
                dv_go   = 1'b1;
                dv_num  = r_prod + LCG_ADD;
                dv_den  = {3'd0, a2};
                n_ret   = S_VAL;
                n_state = S_DIVW;
            end
            S_VAL: begin
                if (c_wave == WAVE_NOISE) begin
                    n_val = signed'(r_dv_rem) - amp_s;
                end else if ((c_wave == WAVE_TRI) && r_hi) begin
                    n_val = amp_s - q_s;
                end else begin
                    n_val = q_s - amp_s;
                end
                n_state = S_ACC;
            end
            S_ACC: begin
                n_mix   = r_mix + 20'(r_val);
                adv_en  = 1'b1;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                if (r_ch == CH_W'(NUM_CHANNELS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = S_CHK;
                end
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            S_DIVW: begin
                if (!r_dv_busy) begin
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_ch     <= '0;
            r_sr     <= SR_RESET;
            r_seed   <= SEED_RESET;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_freq[i]   <= 16'd0;
                r_wave[i]   <= 8'd0;
                r_vol[i]    <= 8'd0;
                r_phase[i]  <= 32'd0;
                r_played[i] <= 32'd0;
            end
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_ch    <= n_ch;
            r_seed  <= n_seed;
            if (i_cfg_wen) begin
                r_sr <= i_cfg_wdata;
            end
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
                r_odata  <= 16'(mix_out);
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (wr_en) begin
                r_freq[CH_W'(in_ch)] <= in_freq;
                r_wave[CH_W'(in_ch)] <= in_wave;
                r_vol[CH_W'(in_ch)]  <= in_vol;
                if (in_freq != 16'd0) begin
                    r_phase[CH_W'(in_ch)]  <= 32'd0;
                    r_played[CH_W'(in_ch)] <= 32'd0;
                end
            end
            if (in_acc && (s_axis_tuser == ACT_STOP)) begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    r_freq[i] <= 16'd0;
                    r_vol[i]  <= 8'd0;
                end
            end
            if (adv_en) begin
                r_phase[r_ch]  <= r_phase[r_ch] + 32'd1;
                r_played[r_ch] <= r_played[r_ch] + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_per  <= n_per;
        r_half <= n_half;
        r_amp  <= n_amp;
        r_hi   <= n_hi;
        r_val  <= n_val;
        r_mix  <= n_mix;
    end

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_go |-> !r_dv_busy)
        else $error("divider restarted while busy");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_dv_busy)
        else $error("divider busy while sequencer idle");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == S_OUT))
        else $error("sample issued outside output step");

    a_adv_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_en |=> (r_state == S_NEXT))
        else $error("channel advance outside accumulate step");

endmodule
